// ===== src/bfiq_pkg.sv =====
package bfiq_pkg;

   localparam logic [31:0] DJB2_START = 32'd5381;
   localparam logic [31:0] SDBM_MULT  = 32'd65599;

   localparam logic CSR_FILTER_BITS = 1'b0;
   localparam logic CSR_HASH_ROUNDS = 1'b1;

   localparam logic FUNC_ADD      = 1'b0;
   localparam logic FUNC_CONTAINS = 1'b1;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_HASH  = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_PROBE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mod_ctrl_type;

endpackage

// ===== src/bfiq_hash.sv =====
module bfiq_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        restart,
   input  logic [7:0]  key_byte,
   output logic [31:0] djb2,
   output logic [31:0] sdbm
);

   logic [31:0] djb2_ff, sdbm_ff;
   logic [31:0] djb2_in, sdbm_in;

   always_comb begin
      djb2_in = djb2_ff;
      sdbm_in = sdbm_ff;
      if (restart) begin
         djb2_in = bfiq_pkg::DJB2_START;
         sdbm_in = '0;
      end else if (step) begin
         djb2_in = {djb2_ff[26:0], 5'd0} + djb2_ff + {24'd0, key_byte};
         sdbm_in = 32'(sdbm_ff * bfiq_pkg::SDBM_MULT) + {24'd0, key_byte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         djb2_ff <= bfiq_pkg::DJB2_START;
         sdbm_ff <= '0;
      end else begin
         djb2_ff <= djb2_in;
         sdbm_ff <= sdbm_in;
      end
   end

   assign djb2 = djb2_ff;
   assign sdbm = sdbm_ff;

endmodule

// ===== src/bfiq_mod.sv =====
module bfiq_mod #(
   parameter int IDX_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [31:0]        dividend,
   input  logic [IDX_W:0]     divisor,
   output bfiq_pkg::mod_ctrl_type ctrl,
   output logic [IDX_W-1:0]   remainder
);

   logic [IDX_W+1:0] rem_ff, rem_in;
   logic [31:0]      quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [IDX_W+1:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[IDX_W:0], quo_ff[31]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign remainder  = rem_ff[IDX_W-1:0];

endmodule

// ===== src/bloom_filter_insert_query.sv =====
// Bloom filter fed one key byte per beat.
// Input channel req_*: func, key_byte, byte_valid, last. A beat with
// byte_valid set folds key_byte into the djb2/sdbm hashes.
// A beat with last runs hash_rounds probes; each probe computes its hash,
// reduces it mod filter_bits in a 32-step shift-subtract unit, then does a
// read-modify-write of the single-port bit memory; each round steps through
// hash, modulo and memory in that order. One rsp_ beat (found, was_add)
// results per last beat.
// The result sits in an output register; the next beat is taken only once
// the result has been taken, so a stalled receiver holds the block.
// csr_* writes: index 0 filter_bits, index 1 hash_rounds; write when idle.
// After reset a clearing pass zeroes all MAX_FILTER_BITS entries of the bit
// memory, one entry a cycle, with req_ready low; csr writes are taken then.
// Filter size 0 counts as 1; values above the maximums saturate.
module bloom_filter_insert_query #(
   parameter int MAX_FILTER_BITS = 65536,
   parameter int MAX_ROUNDS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_key_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic        rsp_was_add,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [16:0] csr_data
);

   localparam int IDX_W = $clog2(MAX_FILTER_BITS);

   bfiq_pkg::state_type state_ff, state_in;
   logic [16:0]      fbits_ff;
   logic [5:0]       rounds_ff;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [5:0]       rnd_ff, rnd_in;
   logic             func_ff, func_in, hit_ff, hit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             probe_ph_ff, probe_ph_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      phash_ff, phash_in;

   logic             mem [MAX_FILTER_BITS];
   logic             rd_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_addr;
   logic             mem_wd;

   logic [31:0]      djb2, sdbm;
   logic             accept, hash_step, hash_restart;
   logic [IDX_W:0]   size;
   logic [5:0]       nrounds;
   logic             mod_start;
   bfiq_pkg::mod_ctrl_type mod_ctrl;
   logic [IDX_W-1:0] mod_rem;
   logic [31:0]      rmul;

   always_ff @(posedge clock) begin
      if (reset) begin
         fbits_ff  <= 17'd65536;
         rounds_ff <= 6'd7;
      end else if (csr_write) begin
         case (csr_index)
            bfiq_pkg::CSR_FILTER_BITS: fbits_ff  <= csr_data;
            bfiq_pkg::CSR_HASH_ROUNDS: rounds_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fbits_ff == 17'd0) size = (IDX_W+1)'(1);
      else if ({15'd0, fbits_ff} > 32'(MAX_FILTER_BITS)) size = (IDX_W+1)'(MAX_FILTER_BITS);
      else size = (IDX_W+1)'(fbits_ff);
      if ({26'd0, rounds_ff} > 32'(MAX_ROUNDS)) nrounds = 6'(MAX_ROUNDS);
      else nrounds = rounds_ff;
   end

   assign req_ready    = (state_ff == bfiq_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept       = req_valid && req_ready;
   assign hash_step    = accept && req_byte_valid;
   assign hash_restart = (state_ff == bfiq_pkg::ST_DONE);

   bfiq_hash u_hash (
      .clock(clock), .reset(reset), .step(hash_step), .restart(hash_restart),
      .key_byte(req_key_byte), .djb2(djb2), .sdbm(sdbm)
   );

   assign rmul = 32'(sdbm * {26'd0, rnd_ff});

   bfiq_mod #(.IDX_W(IDX_W)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(phash_ff),
      .divisor(size), .ctrl(mod_ctrl), .remainder(mod_rem)
   );

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rnd_in       = rnd_ff;
      func_in      = func_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      probe_ph_in  = probe_ph_ff;
      idx_in       = idx_ff;
      phash_in     = phash_ff;
      mod_start    = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = idx_ff;
      mem_wd       = 1'b1;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         bfiq_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            mem_wd   = 1'b0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(MAX_FILTER_BITS - 1)) state_in = bfiq_pkg::ST_IDLE;
         end
         bfiq_pkg::ST_IDLE: begin
            if (accept && req_last) begin
               func_in  = req_func;
               hit_in   = 1'b1;
               rnd_in   = '0;
               state_in = bfiq_pkg::ST_HASH;
            end
         end
         bfiq_pkg::ST_HASH: begin
            if (rnd_ff == nrounds) state_in = bfiq_pkg::ST_DONE;
            else begin
               if (rnd_ff == 6'd0) phash_in = djb2;
               else if (rnd_ff == 6'd1) phash_in = sdbm;
               else phash_in = djb2 + rmul + {26'd0, rnd_ff ^ 6'd2};
               state_in = bfiq_pkg::ST_MOD;
            end
         end
         bfiq_pkg::ST_MOD: begin
            if (!mod_ctrl.busy && !mod_ctrl.done && !probe_ph_ff) begin
               mod_start   = 1'b1;
               probe_ph_in = 1'b1;
            end else if (mod_ctrl.done) begin
               idx_in      = mod_rem;
               probe_ph_in = 1'b0;
               state_in    = bfiq_pkg::ST_PROBE;
            end
         end
         bfiq_pkg::ST_PROBE: begin
            if (!probe_ph_ff) probe_ph_in = 1'b1;
            else begin
               probe_ph_in = 1'b0;
               if (func_ff == bfiq_pkg::FUNC_ADD) mem_we = 1'b1;
               else if (!rd_ff) hit_in = 1'b0;
               rnd_in   = rnd_ff + 6'd1;
               state_in = bfiq_pkg::ST_HASH;
            end
         end
         bfiq_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = bfiq_pkg::ST_IDLE;
         end
         default: state_in = bfiq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfiq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         probe_ph_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         probe_ph_ff  <= probe_ph_in;
      end
      rnd_ff   <= rnd_in;
      func_ff  <= func_in;
      hit_ff   <= hit_in;
      idx_ff   <= idx_in;
      phash_ff <= phash_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = (func_ff == bfiq_pkg::FUNC_CONTAINS) && hit_ff;
   assign rsp_was_add = (func_ff == bfiq_pkg::FUNC_ADD);

endmodule
